FILE: rtl/brw_pkg.sv
// Package for the BMP row to RGB565 writer.
// Holds result records, queue entries, register indexes and sizing constants.
// No dependencies; every other file of the block but brw_if imports it.
package brw_pkg;

    localparam int BRW_MAX_WIDTH  = 1024;
    localparam int BRW_MAX_HEIGHT = 1024;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_CURSOR = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BYTES_PER_PIXEL = 3'd0,
        CFG_IMAGE_WIDTH     = 3'd1,
        CFG_IMAGE_HEIGHT    = 3'd2,
        CFG_X_ORIGIN        = 3'd3,
        CFG_Y_ORIGIN        = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel_color;
        logic [7:0]  cursor_x;
        logic [10:0] cursor_y;
        logic        image_done;
    } result_rec_t;

    typedef struct packed {
        result_rec_t first;
        result_rec_t second;
        logic        two_beats;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_push_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

endpackage

FILE: rtl/brw_if.sv
// Handshake interfaces for the BMP row to RGB565 writer.
// The byte channel carries source bytes; the result channel carries commands.
// No dependencies.
interface brw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink (input valid, input pixel_byte, output ready);
endinterface

interface brw_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] pixel_color;
    logic [7:0]  cursor_x;
    logic [10:0] cursor_y;
    logic        image_done;
    logic        last;

    modport source (output valid, output kind, output pixel_color, output cursor_x,
                    output cursor_y, output image_done, output last, input ready);
    modport sink (input valid, input kind, input pixel_color, input cursor_x,
                  input cursor_y, input image_done, input last, output ready);
endinterface

FILE: rtl/brw_front.sv
// Front end of the writer: configuration registers, row and pixel tracking.
// Turns accepted bytes into queue entries of up to two results; not every byte gives one.
// Depends on brw_pkg and brw_if.
module brw_front #(
    parameter int MAX_WIDTH  = brw_pkg::BRW_MAX_WIDTH,
    parameter int MAX_HEIGHT = brw_pkg::BRW_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [brw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [brw_pkg::CFG_DATA_W-1:0]     cfg_data,
    brw_byte_if.sink                           pixels,
    input  logic                               queue_full,
    output brw_pkg::queue_push_t               push
);
    import brw_pkg::*;

    logic [2:0]  bpp_cfg_reg;
    logic [10:0] width_cfg_reg;
    logic [10:0] height_cfg_reg;
    logic [7:0]  x_origin_reg;
    logic [9:0]  y_origin_reg;

    logic        started_reg, started_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [12:0] rbc_reg, rbc_next;
    logic [10:0] row_reg, row_next;
    logic [10:0] rows_left_reg, rows_left_next;

    logic [2:0]  bpp;
    logic [10:0] w_eff;
    logic [10:0] h_eff;
    logic [12:0] data_bytes;
    logic [12:0] stride_sum;
    logic [12:0] stride;

    logic [1:0]  eff_phase;
    logic [15:0] eff_accum;
    logic [12:0] eff_rbc;
    logic [10:0] eff_row;
    logic [10:0] eff_rows_left;

    logic        in_fire;
    logic        pixel_active;
    logic        pixel_complete;
    logic        pixel_done;
    logic [15:0] contrib;
    logic [15:0] color;
    logic [12:0] rbc_inc;
    logic        row_end;
    logic [10:0] rows_left_dec;
    logic        row_cursor;
    logic [10:0] next_row;

    result_rec_t start_rec;
    result_rec_t pixel_rec;
    result_rec_t row_rec;

    function automatic logic [15:0] contribute(input logic [2:0] size, input logic [1:0] ph,
                                               input logic [7:0] b);
        logic [15:0] v;
        v = '0;
        if (size == 3'd2) begin
            case (ph)
                2'd0:    v = {7'b0, b[7:5], 1'b0, b[4:0]};
                2'd1:    v = {b[6:0], 9'b0};
                default: v = '0;
            endcase
        end else begin
            case (ph)
                2'd0:    v = {11'b0, b[7:3]};
                2'd1:    v = {5'b0, b[7:2], 5'b0};
                2'd2:    v = {b[7:3], 11'b0};
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bpp_cfg_reg    <= 3'd3;
            width_cfg_reg  <= 11'd1;
            height_cfg_reg <= 11'd1;
            x_origin_reg   <= '0;
            y_origin_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BYTES_PER_PIXEL: bpp_cfg_reg    <= cfg_data[2:0];
                CFG_IMAGE_WIDTH:     width_cfg_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:    height_cfg_reg <= cfg_data;
                CFG_X_ORIGIN:        x_origin_reg   <= cfg_data[7:0];
                CFG_Y_ORIGIN:        y_origin_reg   <= cfg_data[9:0];
                default:             ;
            endcase
        end
    end

    always_comb begin
        if (bpp_cfg_reg == 3'd2 || bpp_cfg_reg == 3'd4) begin
            bpp = bpp_cfg_reg;
        end else begin
            bpp = 3'd3;
        end

        if (width_cfg_reg == '0) begin
            w_eff = 11'd1;
        end else if ({2'b0, width_cfg_reg} > 13'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = width_cfg_reg;
        end

        if (height_cfg_reg == '0) begin
            h_eff = 11'd1;
        end else if ({2'b0, height_cfg_reg} > 13'(MAX_HEIGHT)) begin
            h_eff = 11'(MAX_HEIGHT);
        end else begin
            h_eff = height_cfg_reg;
        end

        case (bpp)
            3'd2:    data_bytes = {1'b0, w_eff, 1'b0};
            3'd4:    data_bytes = {w_eff, 2'b0};
            default: data_bytes = {1'b0, w_eff, 1'b0} + {2'b0, w_eff};
        endcase
        stride_sum = data_bytes + 13'd3;
        stride     = {stride_sum[12:2], 2'b0};
    end

    always_comb begin
        if (started_reg) begin
            eff_phase     = phase_reg;
            eff_accum     = accum_reg;
            eff_rbc       = rbc_reg;
            eff_row       = row_reg;
            eff_rows_left = rows_left_reg;
        end else begin
            eff_phase     = '0;
            eff_accum     = '0;
            eff_rbc       = '0;
            eff_row       = h_eff - 11'd1 + {1'b0, y_origin_reg};
            eff_rows_left = h_eff;
        end

        in_fire        = pixels.valid && pixels.ready;
        pixel_active   = eff_rbc < data_bytes;
        contrib        = contribute(bpp, eff_phase, pixels.pixel_byte);
        color          = eff_accum | contrib;
        pixel_complete = pixel_active && (({1'b0, eff_phase} + 3'd1) >= bpp);
        pixel_done     = (eff_rows_left <= 11'd1)
                         && (({1'b0, eff_rbc} + 14'd1) >= {1'b0, data_bytes});
        rbc_inc        = eff_rbc + 13'd1;
        row_end        = rbc_inc >= stride;
        rows_left_dec  = eff_rows_left - 11'd1;
        row_cursor     = row_end && (rows_left_dec != '0);
        next_row       = eff_row - 11'd1;

        start_rec = '{kind: KIND_CURSOR, pixel_color: '0, cursor_x: x_origin_reg,
                      cursor_y: eff_row, image_done: 1'b0};
        pixel_rec = '{kind: KIND_PIXEL, pixel_color: color, cursor_x: '0,
                      cursor_y: '0, image_done: pixel_done};
        row_rec   = '{kind: KIND_CURSOR, pixel_color: '0, cursor_x: x_origin_reg,
                      cursor_y: next_row, image_done: 1'b0};

        push.valid = in_fire && (!started_reg || pixel_complete || row_cursor);
        push.entry.two_beats = (!started_reg && (pixel_complete || row_cursor))
                               || (pixel_complete && row_cursor);
        if (!started_reg) begin
            push.entry.first  = start_rec;
            push.entry.second = pixel_complete ? pixel_rec : row_rec;
        end else if (pixel_complete) begin
            push.entry.first  = pixel_rec;
            push.entry.second = row_rec;
        end else begin
            push.entry.first  = row_rec;
            push.entry.second = row_rec;
        end

        pixels.ready = !queue_full;

        started_next   = started_reg;
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        rbc_next       = rbc_reg;
        row_next       = row_reg;
        rows_left_next = rows_left_reg;
        if (in_fire) begin
            started_next   = !(row_end && (rows_left_dec == '0));
            rbc_next       = row_end ? '0 : rbc_inc;
            rows_left_next = row_end ? rows_left_dec : eff_rows_left;
            row_next       = row_cursor ? next_row : eff_row;
            if (row_end || pixel_complete) begin
                phase_next = '0;
                accum_next = '0;
            end else if (pixel_active) begin
                phase_next = eff_phase + 2'd1;
                accum_next = color;
            end else begin
                phase_next = eff_phase;
                accum_next = eff_accum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            started_reg   <= 1'b0;
            phase_reg     <= '0;
            accum_reg     <= '0;
            rbc_reg       <= '0;
            row_reg       <= '0;
            rows_left_reg <= '0;
        end else begin
            started_reg   <= started_next;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            rbc_reg       <= rbc_next;
            row_reg       <= row_next;
            rows_left_reg <= rows_left_next;
        end
    end

endmodule

FILE: rtl/brw_queue.sv
// Short queue between the front end and the output stage of the writer.
// Holds command entries of one or two results each.
// Depends on brw_pkg.
module brw_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brw_pkg::queue_push_t  push,
    input  logic                  pop,
    output brw_pkg::queue_head_t  head,
    output logic                  full
);
    import brw_pkg::*;

    queue_entry_t             slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     do_push;
    logic                     do_pop;

    always_comb begin
        full       = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
        head.valid = count_reg != '0;
        head.entry = slots[rd_ptr_reg];
        do_push    = push.valid && !full;
        do_pop     = pop && head.valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/brw_back.sv
// Output stage of the writer: splits queue entries into result beats.
// Drives the result channel from a registered output stage.
// Depends on brw_pkg and brw_if.
module brw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brw_pkg::queue_head_t  head,
    output logic                  pop,
    brw_result_if.source          results
);
    import brw_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        second_reg, second_next;
    result_rec_t out_rec_reg;
    logic        out_last_reg;
    logic        load;
    logic        take;
    logic        last_beat;
    result_rec_t beat_rec;

    always_comb begin
        load      = !out_valid_reg || results.ready;
        take      = load && head.valid;
        last_beat = second_reg || !head.entry.two_beats;
        beat_rec  = second_reg ? head.entry.second : head.entry.first;
        pop       = take && last_beat;

        second_next    = take ? !last_beat : second_reg;
        out_valid_next = take ? 1'b1 : (load ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk) begin
        if (take) begin
            out_rec_reg  <= beat_rec;
            out_last_reg <= last_beat;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = out_rec_reg.kind;
    assign results.pixel_color = out_rec_reg.pixel_color;
    assign results.cursor_x    = out_rec_reg.cursor_x;
    assign results.cursor_y    = out_rec_reg.cursor_y;
    assign results.image_done  = out_rec_reg.image_done;
    assign results.last        = out_last_reg;

endmodule

FILE: rtl/bmp_rows_to_rgb565_writer_unit.sv
// Top level of the BMP row to RGB565 writer: front end, queue and output stage.
// Depends on brw_pkg, brw_if, brw_front, brw_queue and brw_back.
//
// The block takes the pixel-data bytes of a bottom-up BMP, padding included, one byte per
// cycle on the pixels channel and gives set-cursor commands and RGB565 pixel writes on the
// results channel. A byte is taken whenever the four-entry queue has room. Most bytes cause
// at most one result, and the output stage gives one beat per cycle while results are taken.
// The last data byte of a row without padding, when more rows follow, causes a pixel write
// and a set-cursor command, given as two beats; the queue absorbs these, and the sustained
// rate is set by the result port at one beat per cycle. The user must write registers only
// while the block is idle, which the block does not enforce; writes take effect on the next byte.
module bmp_rows_to_rgb565_writer_unit #(
    parameter int MAX_WIDTH  = brw_pkg::BRW_MAX_WIDTH,
    parameter int MAX_HEIGHT = brw_pkg::BRW_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [brw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [brw_pkg::CFG_DATA_W-1:0]   cfg_data,
    brw_byte_if.sink                         pixels,
    brw_result_if.source                     results
);
    import brw_pkg::*;

    queue_push_t push;
    queue_head_t head;
    logic        queue_full;
    logic        pop;

    brw_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixels     (pixels),
        .queue_full (queue_full),
        .push       (push)
    );

    brw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (queue_full)
    );

    brw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

FILE: rtl/brw_checker.sv
// Port-level checks for the BMP row to RGB565 writer, with the bind that attaches them.
// Depends on bmp_rows_to_rgb565_writer_unit and brw_pkg.
module brw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_kind,
    input logic [15:0] res_pixel_color,
    input logic [7:0]  res_cursor_x,
    input logic [10:0] res_cursor_y,
    input logic        res_image_done,
    input logic        res_last
);
    import brw_pkg::*;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_pixel_color) && $stable(res_cursor_x)
            && $stable(res_cursor_y) && $stable(res_image_done) && $stable(res_last))
        else $error("result beat changed while stalled");

    a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_kind == KIND_CURSOR && res_pixel_color == '0 && !res_image_done)
            || (res_kind == KIND_PIXEL && res_cursor_x == '0 && res_cursor_y == '0))
        else $error("unused fields of a result beat are not zero");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_image_done |-> res_kind == KIND_PIXEL && res_last)
        else $error("end of image not on a final pixel write");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |-> res_kind == KIND_PIXEL
            ##1 (res_valid && res_kind == KIND_CURSOR && res_last))
        else $error("two-result byte not followed at once by its cursor command");

endmodule

bind bmp_rows_to_rgb565_writer_unit brw_checker u_brw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (results.valid),
    .res_ready       (results.ready),
    .res_kind        (results.kind),
    .res_pixel_color (results.pixel_color),
    .res_cursor_x    (results.cursor_x),
    .res_cursor_y    (results.cursor_y),
    .res_image_done  (results.image_done),
    .res_last        (results.last)
);
